### rtl/assert_macros.svh
// Assertion macros for the RTL files, included by byte_pattern_search_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define BPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define BPS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Types, constants and helpers shared by the byte pattern search block.
// ----------------------------------------------------------------------------
package bps_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int SOURCE_MAX_DEF  = 65536;

	localparam int BYTE_W     = 8;
	localparam int OFFSET_W   = 16;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_LEN_W  = 5;
	localparam int PAT_BYTES  = 16;
	localparam int PAT_W      = PAT_BYTES * BYTE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_FWD   = 2'd3;

	typedef struct packed {
		logic                last;
		logic                cmp_en;
		logic [OFFSET_W-1:0] offset;
	} bps_s1_t;

	function automatic logic [BYTE_W-1:0] pattern_at(input logic [PAT_W-1:0] pat,
		input int k);
		logic [BYTE_W-1:0] b;
		b = '0;
		if (k < PAT_BYTES) begin
			b = pat[BYTE_W*k +: BYTE_W];
		end
		return b;
	endfunction

endpackage

### rtl/bps_in_if.sv
// ----------------------------------------------------------------------------
// bps_in_if
// Source byte channel with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bps_in_if import bps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] source_byte;
	logic              last_byte;

	modport source (output valid, output source_byte, output last_byte, input ready);
	modport sink (input valid, input source_byte, input last_byte, output ready);
endinterface

### rtl/bps_out_if.sv
// ----------------------------------------------------------------------------
// bps_out_if
// Search result channel with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bps_out_if import bps_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                match_found;
	logic [OFFSET_W-1:0] match_offset;

	modport source (output valid, output match_found, output match_offset, input ready);
	modport sink (input valid, input match_found, input match_offset, output ready);
endinterface

### rtl/bps_window.sv
// ----------------------------------------------------------------------------
// bps_window
// Input stage: shift window of recent bytes, buffer byte counter and the
// registered per-word compare control.
// ----------------------------------------------------------------------------
module bps_window import bps_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int SOURCE_MAX  = SOURCE_MAX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_fire,
	input  logic [BYTE_W-1:0]                   source_byte,
	input  logic                                last_byte,
	input  logic [CFG_LEN_W-1:0]                eff_len,
	input  logic                                s2_take,
	output logic [PATTERN_MAX-1:0][BYTE_W-1:0] window,
	output logic                                valid_s1,
	output bps_s1_t                             info_s1
);
	localparam int CNT_W = $clog2(SOURCE_MAX + 1);

	logic [CNT_W-1:0]                    count_q;
	logic [CNT_W-1:0]                    count_inc;
	logic                                room;
	logic [PATTERN_MAX-1:0][BYTE_W-1:0] window_q;

	assign room      = count_q < CNT_W'(SOURCE_MAX);
	assign count_inc = count_q + CNT_W'(1);
	assign window    = window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
				if (last_byte) begin
					count_q <= '0;
				end else if (room) begin
					count_q <= count_inc;
				end
			end else if (s2_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			info_s1.last   <= last_byte;
			info_s1.cmp_en <= room && (count_inc >= CNT_W'(eff_len));
			info_s1.offset <= OFFSET_W'(count_inc - CNT_W'(eff_len));
			if (room) begin
				for (int k = PATTERN_MAX - 1; k > 0; k--) begin
					window_q[k] <= window_q[k-1];
				end
				window_q[0] <= source_byte;
			end
		end
	end
endmodule

### rtl/bps_match.sv
// ----------------------------------------------------------------------------
// bps_match
// Parallel compare of the newest pattern-length window bytes with the pattern.
// ----------------------------------------------------------------------------
module bps_match import bps_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  logic [PATTERN_MAX-1:0][BYTE_W-1:0] window,
	input  logic [PAT_W-1:0]                    pattern,
	input  logic [CFG_LEN_W-1:0]                eff_len,
	output logic                                equal
);
	localparam int WIN_IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	always_comb begin
		logic [CFG_LEN_W-1:0] idx;
		equal = 1'b1;
		idx   = '0;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			if (k < int'(eff_len)) begin
				idx = eff_len - CFG_LEN_W'(k) - CFG_LEN_W'(1);
				if (pattern_at(pattern, k) != window[WIN_IW'(idx)]) begin
					equal = 1'b0;
				end
			end
		end
	end
endmodule

### rtl/bps_result.sv
// ----------------------------------------------------------------------------
// bps_result
// Match tracking for the open buffer and the registered result word.
// ----------------------------------------------------------------------------
module bps_result import bps_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s1,
	input  bps_s1_t       info_s1,
	input  logic          equal,
	input  logic          search_fwd,
	output logic          stall,
	output logic          s2_take,
	bps_out_if.source     out_ch
);
	logic                hit_q;
	logic [OFFSET_W-1:0] hit_off_q;
	logic                new_hit;
	logic                out_valid_q;
	logic                found_q;
	logic [OFFSET_W-1:0] offset_q;

	assign stall   = valid_s1 && info_s1.last && out_valid_q && !out_ch.ready;
	assign s2_take = valid_s1 && !stall;
	assign new_hit = info_s1.cmp_en && equal && (!hit_q || !search_fwd);

	assign out_ch.valid        = out_valid_q;
	assign out_ch.match_found  = found_q;
	assign out_ch.match_offset = offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= 1'b0;
			hit_off_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_take && info_s1.last) begin
				out_valid_q <= 1'b1;
				hit_q       <= 1'b0;
				hit_off_q   <= '0;
			end else begin
				if (out_ch.ready) begin
					out_valid_q <= 1'b0;
				end
				if (s2_take && new_hit) begin
					hit_q     <= 1'b1;
					hit_off_q <= info_s1.offset;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take && info_s1.last) begin
			found_q  <= hit_q || new_hit;
			offset_q <= new_hit ? info_s1.offset : (hit_q ? hit_off_q : '0);
		end
	end
endmodule

### rtl/byte_pattern_search_core.sv
// ----------------------------------------------------------------------------
// byte_pattern_search_core
// Streaming search for a byte pattern of 1 to 16 bytes in a byte buffer.
// ----------------------------------------------------------------------------
// The block takes one source word per cycle while the input is not stalled and
// returns one result word per buffer. The word marked last_byte passes the input
// register and then loads the result register. The input register feeds a
// parallel window compare; the sustained rate is one byte per clock unless a
// stall holds the input. The input stalls only while a closing word waits
// behind an unread result in the output register. The pattern, length and
// direction registers are to be written while no buffer is open.
module byte_pattern_search_core import bps_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int SOURCE_MAX  = SOURCE_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	bps_in_if.sink                in_ch,
	bps_out_if.source             out_ch
);
`include "assert_macros.svh"

	localparam int LEN_CAP = (PATTERN_MAX < 31) ? PATTERN_MAX : 31;

	logic [CFG_DATA_W-1:0]               pat_lo_q;
	logic [CFG_DATA_W-1:0]               pat_hi_q;
	logic [CFG_LEN_W-1:0]                len_q;
	logic                                fwd_q;
	logic [CFG_LEN_W-1:0]                eff_len;
	logic                                in_fire;
	logic                                stall;
	logic                                s2_take;
	logic                                equal;
	logic                                valid_s1;
	bps_s1_t                             info_s1;
	logic [PATTERN_MAX-1:0][BYTE_W-1:0] window;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			len_q    <= CFG_LEN_W'(1);
			fwd_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PATTERN_LOW:  pat_lo_q <= cfg_wdata;
				CFG_PATTERN_HIGH: pat_hi_q <= cfg_wdata;
				CFG_PATTERN_LEN:  len_q    <= cfg_wdata[CFG_LEN_W-1:0];
				CFG_SEARCH_FWD:   fwd_q    <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (len_q == '0) begin
			eff_len = CFG_LEN_W'(1);
		end else if (int'(len_q) > LEN_CAP) begin
			eff_len = CFG_LEN_W'(LEN_CAP);
		end else begin
			eff_len = len_q;
		end
	end

	assign in_ch.ready = !stall;
	assign in_fire     = in_ch.valid && !stall;

	bps_window #(
		.PATTERN_MAX (PATTERN_MAX),
		.SOURCE_MAX  (SOURCE_MAX)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.source_byte (in_ch.source_byte),
		.last_byte   (in_ch.last_byte),
		.eff_len     (eff_len),
		.s2_take     (s2_take),
		.window      (window),
		.valid_s1    (valid_s1),
		.info_s1     (info_s1)
	);

	bps_match #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_match (
		.window  (window),
		.pattern ({pat_hi_q, pat_lo_q}),
		.eff_len (eff_len),
		.equal   (equal)
	);

	bps_result u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.info_s1    (info_s1),
		.equal      (equal),
		.search_fwd (fwd_q),
		.stall      (stall),
		.s2_take    (s2_take),
		.out_ch     (out_ch)
	);

	`BPS_ASSERT(a_result_after_last, $rose(out_ch.valid) |-> $past(valid_s1 && info_s1.last), "result word without a closing input word")
	`BPS_ASSERT(a_offset_zero, out_ch.valid && !out_ch.match_found |-> out_ch.match_offset == '0, "nonzero offset on a miss")
	`BPS_ASSERT(a_stall_cause, !in_ch.ready |-> out_ch.valid && valid_s1 && info_s1.last, "input stalled without a pending result")
	`BPS_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_ch.valid && !valid_s1, "activity during reset")
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench for byte_pattern_search_core. Source words are sent
// through the input channel under random idling on both sides. A predictor
// keeps its own shift window and per-buffer state, pushes one expected result
// per closing word, and a checker compares every result word field by field.
// Directed buffers cover the reset pattern, the length limits, both search
// directions, and overlapping and end-of-buffer matches. Random buffers with
// embedded pattern copies follow.
// ----------------------------------------------------------------------------
module testbench;
	import bps_pkg::*;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] offset;
	} search_result_t;

	typedef logic [BYTE_W-1:0] byte_q_t [$];

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bps_in_if  in_ch ();
	bps_out_if out_ch ();

	byte_pattern_search_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	logic [CFG_DATA_W-1:0] pattern_low_q;
	logic [CFG_DATA_W-1:0] pattern_high_q;
	logic [CFG_LEN_W-1:0]  pattern_len_q;
	logic                  forward_q;
	logic [BYTE_W-1:0]     window_q [PAT_BYTES];
	int unsigned           seen_count;
	logic                  hit_q;
	logic [OFFSET_W-1:0]   hit_offset_q;

	search_result_t pending_results [$];
	int unsigned    mismatch_count;
	int unsigned    results_checked;
	int unsigned    buffers_sent;
	int unsigned    words_sent;
	int unsigned    src_idle_pct;
	int unsigned    sink_idle_pct;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int effective_length(input logic [CFG_LEN_W-1:0] len);
		if (len == '0) begin
			return 1;
		end
		if (len > PATTERN_MAX_DEF) begin
			return PATTERN_MAX_DEF;
		end
		return int'(len);
	endfunction

	task automatic clear_search_state();
		foreach (window_q[k]) begin
			window_q[k] = '0;
		end
		seen_count   = 0;
		hit_q        = 1'b0;
		hit_offset_q = '0;
	endtask

	task automatic predict_word(input logic [BYTE_W-1:0] b, input logic l);
		int             len;
		logic [PAT_W-1:0] pat;
		logic           equal;
		search_result_t r;
		if (seen_count < SOURCE_MAX_DEF) begin
			len = effective_length(pattern_len_q);
			for (int k = PAT_BYTES - 1; k > 0; k--) begin
				window_q[k] = window_q[k-1];
			end
			window_q[0] = b;
			seen_count++;
			if (seen_count >= len) begin
				pat   = {pattern_high_q, pattern_low_q};
				equal = 1'b1;
				for (int k = 0; k < len; k++) begin
					if (pat[BYTE_W*k +: BYTE_W] != window_q[len-1-k]) begin
						equal = 1'b0;
					end
				end
				if (equal && (!hit_q || !forward_q)) begin
					hit_q        = 1'b1;
					hit_offset_q = OFFSET_W'(seen_count - len);
				end
			end
		end
		if (l) begin
			r.found  = hit_q;
			r.offset = hit_q ? hit_offset_q : '0;
			pending_results.push_back(r);
			clear_search_state();
		end
	endtask

	task automatic send_word(input logic [BYTE_W-1:0] b, input logic l);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.source_byte <= b;
		in_ch.last_byte   <= l;
		do @(posedge clk); while (!in_ch.ready);
		predict_word(b, l);
		words_sent++;
	endtask

	task automatic send_bytes(input byte_q_t data);
		foreach (data[i]) begin
			send_word(data[i], i == data.size() - 1);
		end
		buffers_sent++;
	endtask

	task automatic settle_block();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(input logic [CFG_DATA_W-1:0] lo,
		input logic [CFG_DATA_W-1:0] hi, input logic [CFG_LEN_W-1:0] len,
		input logic fwd);
		settle_block();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PATTERN_LOW;
		cfg_wdata <= lo;
		@(posedge clk);
		pattern_low_q = lo;
		cfg_index <= CFG_PATTERN_HIGH;
		cfg_wdata <= hi;
		@(posedge clk);
		pattern_high_q = hi;
		cfg_index <= CFG_PATTERN_LEN;
		cfg_wdata <= CFG_DATA_W'(len);
		@(posedge clk);
		pattern_len_q = len;
		cfg_index <= CFG_SEARCH_FWD;
		cfg_wdata <= CFG_DATA_W'(fwd);
		@(posedge clk);
		forward_q = fwd;
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_pattern();
		send_bytes({8'h05, 8'h00, 8'h00});
		send_bytes({8'hFF});
	endtask

	task automatic test_length_limits();
		logic [CFG_DATA_W-1:0] lo;
		logic [CFG_DATA_W-1:0] hi;
		byte_q_t               data;
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		write_config(lo, hi, 5'd31, 1'b1);
		for (int k = 0; k < 8; k++) begin
			data.push_back(lo[BYTE_W*k +: BYTE_W]);
		end
		for (int k = 0; k < 8; k++) begin
			data.push_back(hi[BYTE_W*k +: BYTE_W]);
		end
		send_bytes(data);
		write_config(64'h0000_0000_0000_00A5, '1, 5'd0, 1'b1);
		send_bytes({8'hA5});
		write_config(64'h0000_0000_0403_0201, '0, 5'd4, 1'b1);
		send_bytes({8'h01, 8'h02, 8'h03});
	endtask

	task automatic test_search_direction();
		write_config(64'hFFFF_FFFF_FFFF_AAAA, '1, 5'd2, 1'b0);
		send_bytes({8'hAA, 8'hAA, 8'hAA});
		write_config(64'hFFFF_FFFF_FFFF_AAAA, '1, 5'd2, 1'b1);
		send_bytes({8'hAA, 8'hAA, 8'hAA});
	endtask

	task automatic test_match_at_end();
		write_config(64'h0000_0000_0033_2211, '0, 5'd3, 1'b1);
		send_bytes({8'h00, 8'h11, 8'h22, 8'h33});
	endtask

	task automatic test_random_buffers(input int unsigned word_budget);
		int unsigned           start_words;
		int unsigned           setting_left;
		int unsigned           r;
		int                    len;
		int                    size;
		int                    pos;
		logic [BYTE_W-1:0]     alpha [4];
		logic [BYTE_W-1:0]     pat_b [PAT_BYTES];
		logic [CFG_DATA_W-1:0] lo;
		logic [CFG_DATA_W-1:0] hi;
		logic [CFG_LEN_W-1:0]  len_field;
		byte_q_t               data;
		start_words  = words_sent;
		setting_left = 0;
		while (words_sent - start_words < word_budget) begin
			if (setting_left == 0) begin
				foreach (alpha[k]) begin
					alpha[k] = BYTE_W'($urandom);
				end
				r = $urandom_range(3);
				foreach (pat_b[k]) begin
					pat_b[k] = (r == 0) ? BYTE_W'($urandom) : alpha[$urandom_range(3)];
				end
				for (int k = 0; k < 8; k++) begin
					lo[BYTE_W*k +: BYTE_W] = pat_b[k];
					hi[BYTE_W*k +: BYTE_W] = pat_b[k+8];
				end
				r = $urandom_range(99);
				if (r < 50) begin
					len_field = CFG_LEN_W'($urandom_range(1, 4));
				end else if (r < 85) begin
					len_field = CFG_LEN_W'($urandom_range(5, 16));
				end else if (r < 92) begin
					len_field = '0;
				end else begin
					len_field = CFG_LEN_W'($urandom_range(17, 31));
				end
				write_config(lo, hi, len_field, 1'($urandom));
				len          = effective_length(len_field);
				setting_left = $urandom_range(3, 10);
			end
			data.delete();
			size = ($urandom_range(99) < 80) ? $urandom_range(1, len + 12)
				: $urandom_range(1, 64);
			for (int i = 0; i < size; i++) begin
				data.push_back(($urandom_range(99) < 85) ? alpha[$urandom_range(3)]
					: BYTE_W'($urandom));
			end
			if (size >= len && $urandom_range(99) < 60) begin
				repeat ($urandom_range(1, 2)) begin
					pos = $urandom_range(0, size - len);
					for (int k = 0; k < len; k++) begin
						data[pos+k] = pat_b[k];
					end
				end
			end
			send_bytes(data);
			setting_left--;
		end
	endtask

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin : check_results
		search_result_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result word: match_found %0d, match_offset %0d",
					out_ch.match_found, out_ch.match_offset);
				mismatch_count++;
			end else begin
				exp_r = pending_results.pop_front();
				results_checked++;
				if (out_ch.match_found !== exp_r.found) begin
					$error("match_found: expected %0d, actual %0d",
						exp_r.found, out_ch.match_found);
					mismatch_count++;
				end
				if (out_ch.match_offset !== exp_r.offset) begin
					$error("match_offset: expected %0d, actual %0d",
						exp_r.offset, out_ch.match_offset);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_PATTERN_LOW;
		cfg_wdata         = '0;
		in_ch.valid       = 1'b0;
		in_ch.source_byte = '0;
		in_ch.last_byte   = 1'b0;
		pattern_low_q     = '0;
		pattern_high_q    = '0;
		pattern_len_q     = 5'd1;
		forward_q         = 1'b1;
		mismatch_count    = 0;
		results_checked   = 0;
		buffers_sent      = 0;
		words_sent        = 0;
		src_idle_pct      = 25;
		sink_idle_pct     = 49;
		clear_search_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_pattern();
		test_length_limits();
		test_search_direction();
		test_match_at_end();
		test_random_buffers(270);
		settle_block();
		src_idle_pct  = 49;
		sink_idle_pct = 25;
		test_random_buffers(270);
		settle_block();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		test_random_buffers(270);
		settle_block();

		$display("Checked %0d result words from %0d buffers and %0d source words.",
			results_checked, buffers_sent, words_sent);
		$display("Covered both directions, lengths 0 to 31, and matches at buffer edges.");
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/bps_pkg.sv
rtl/bps_in_if.sv
rtl/bps_out_if.sv
rtl/bps_window.sv
rtl/bps_match.sv
rtl/bps_result.sv
rtl/byte_pattern_search_core.sv
tb/testbench.sv
